### design/rpns_pkg.sv
package rpns_pkg;

    localparam int MAX_NODES = 1024;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int DIST_W  = 31;
    localparam int IDX_W   = 10;
    localparam int DIR_FRAC = 14;

    localparam logic [IDX_W-1:0] IDX_CAP =
        (MAX_NODES > 1024) ? IDX_W'(1023) : IDX_W'(MAX_NODES - 1);

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 16;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam int D_W   = COORD_W + 1;
    localparam int M_W   = D_W + DIR_W;
    localparam int DOT_W = M_W + 2;
    localparam int E_W   = D_W + DIR_FRAC + 2;
    localparam int P_W   = 30;
    localparam int SQ_W  = 2 * P_W;
    localparam int SZ2_W = 2 * DIST_W;

    typedef enum logic {
        KIND_SETUP = 1'b0,
        KIND_NODE  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic                       last;
        logic [IDX_W-1:0]           idx;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic signed [DIR_W-1:0]    dir_x;
        logic signed [DIR_W-1:0]    dir_y;
        logic signed [DIR_W-1:0]    dir_z;
        logic [DIST_W-1:0]          val;
    } item_t;

endpackage

### design/rpns_queue.sv
module rpns_queue
    import rpns_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push) |=> empty)
        else $error("queue left empty without a push");
`endif

endmodule

### design/rpns_front.sv
module rpns_front
    import rpns_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // px, py, pz, dir_x, dir_y, dir_z, max_dist, node_size
    input  logic                 s_axis_tuser,  // kind
    input  logic                 s_axis_tlast,
    output logic                 push,
    output item_t                push_item,
    input  logic                 full
);

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    kind_t            kind;

    assign kind          = kind_t'(s_axis_tuser);
    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && !full;

    always_comb
    begin
        push_item.kind  = kind;
        push_item.last  = s_axis_tlast;
        push_item.idx   = cnt_reg;
        push_item.px    = s_axis_tdata[31:0];
        push_item.py    = s_axis_tdata[63:32];
        push_item.pz    = s_axis_tdata[95:64];
        push_item.dir_x = s_axis_tdata[111:96];
        push_item.dir_y = s_axis_tdata[127:112];
        push_item.dir_z = s_axis_tdata[143:128];
        push_item.val   = (kind == KIND_SETUP) ? s_axis_tdata[174:144] : s_axis_tdata[205:175];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
        begin
            if (kind == KIND_SETUP)
            begin
                cnt_next = '0;
            end
            else if (cnt_reg < IDX_CAP)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= IDX_CAP)
        else $error("node counter past cap");
`endif

endmodule

### design/rpns_back.sv
module rpns_back
    import rpns_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  item_t                pop_item,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // node_index
    output logic                 m_axis_tuser   // hit
);

    typedef struct packed {
        kind_t                   kind;
        logic                    last;
        logic [IDX_W-1:0]        idx;
        logic [DIST_W-1:0]       val;
        logic [2:0][D_W-1:0]     d;
        logic [2:0][DIR_W-1:0]   dir;
        logic [2:0][M_W-1:0]     m;
        logic [DOT_W-1:0]        dot;
        logic [DIST_W-1:0]       t;
        logic                    rej;
        logic [2:0][E_W-1:0]     e;
        logic [2:0][P_W-1:0]     p;
        logic [2:0][SQ_W-1:0]    sq;
        logic [SZ2_W-1:0]        size2;
    } stage_t;

    logic en;
    logic [7:0] vld_reg;

    stage_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg, st7_reg, st8_reg;
    stage_t st1_next, st2_next, st3_next, st4_next, st5_next, st6_next, st7_next, st8_next;

    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [DIR_W-1:0]   dir_reg [3];
    logic signed [COORD_W-1:0] pos [3];
    logic signed [DIR_W-1:0]   pdir [3];

    logic [DIST_W-1:0] best_reg;
    logic [DIST_W-1:0] best_next;
    logic [IDX_W-1:0]  bidx_reg;
    logic [IDX_W-1:0]  bidx_next;
    logic              found_reg;
    logic              found_next;

    logic              out_vld_reg;
    logic              out_vld_next;
    logic              out_hit_reg;
    logic              out_hit_next;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [IDX_W-1:0]  out_idx_next;

    assign en  = !out_vld_reg || m_axis_tready;
    assign pop = en && !empty;

    assign pos[0]  = pop_item.px;
    assign pos[1]  = pop_item.py;
    assign pos[2]  = pop_item.pz;
    assign pdir[0] = pop_item.dir_x;
    assign pdir[1] = pop_item.dir_y;
    assign pdir[2] = pop_item.dir_z;

    always_comb
    begin
        st1_next      = st1_reg;
        st1_next.kind = pop_item.kind;
        st1_next.last = pop_item.last;
        st1_next.idx  = pop_item.idx;
        st1_next.val  = pop_item.val;
        for (int i = 0; i < 3; i++)
        begin
            st1_next.d[i]   = D_W'(pos[i]) - D_W'(org_reg[i]);
            st1_next.dir[i] = dir_reg[i];
        end
    end

    always_comb
    begin
        st2_next = st1_reg;
        for (int i = 0; i < 3; i++)
        begin
            st2_next.m[i] = M_W'($signed(st1_reg.d[i])) * M_W'($signed(st1_reg.dir[i]));
        end
    end

    always_comb
    begin
        st3_next     = st2_reg;
        st3_next.dot = DOT_W'($signed(st2_reg.m[0])) + DOT_W'($signed(st2_reg.m[1]))
                     + DOT_W'($signed(st2_reg.m[2]));
    end

    always_comb
    begin
        st4_next     = st3_reg;
        st4_next.rej = st3_reg.dot[DOT_W-1] | (|st3_reg.dot[DOT_W-2:DIR_FRAC+DIST_W]);
        st4_next.t   = st3_reg.dot[DIR_FRAC+DIST_W-1:DIR_FRAC];
    end

    always_comb
    begin
        st5_next = st4_reg;
        for (int i = 0; i < 3; i++)
        begin
            st5_next.e[i] = (E_W'($signed(st4_reg.d[i])) <<< DIR_FRAC)
                          - E_W'($signed(st4_reg.dir[i])) * E_W'($signed({1'b0, st4_reg.t}));
        end
    end

    always_comb
    begin
        logic [E_W-1:0]          mag;
        logic [E_W-DIR_FRAC-1:0] pw;
        st6_next = st5_reg;
        for (int i = 0; i < 3; i++)
        begin
            mag = st5_reg.e[i][E_W-1] ? (~st5_reg.e[i] + 1'b1) : st5_reg.e[i];
            pw  = mag[E_W-1:DIR_FRAC];
            st6_next.p[i] = pw[P_W-1:0];
            if (|pw[E_W-DIR_FRAC-1:P_W])
            begin
                st6_next.rej = 1'b1;
            end
        end
    end

    always_comb
    begin
        st7_next = st6_reg;
        for (int i = 0; i < 3; i++)
        begin
            st7_next.sq[i] = SQ_W'(st6_reg.p[i]) * SQ_W'(st6_reg.p[i]);
        end
        st7_next.size2 = SZ2_W'(st6_reg.val) * SZ2_W'(st6_reg.val);
    end

    always_comb
    begin
        logic [SZ2_W-1:0] sum;
        st8_next = st7_reg;
        sum = SZ2_W'(st7_reg.sq[0]) + SZ2_W'(st7_reg.sq[1]) + SZ2_W'(st7_reg.sq[2]);
        if ({sum, 2'b00} >= (SZ2_W+2)'(st7_reg.size2))
        begin
            st8_next.rej = 1'b1;
        end
    end

    always_comb
    begin
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        found_next   = found_reg;
        out_vld_next = 1'b0;
        if (vld_reg[7])
        begin
            if (st8_reg.kind == KIND_SETUP)
            begin
                best_next  = st8_reg.val;
                bidx_next  = '0;
                found_next = 1'b0;
            end
            else
            begin
                if (!st8_reg.rej && (st8_reg.t < best_reg))
                begin
                    best_next  = st8_reg.t;
                    bidx_next  = st8_reg.idx;
                    found_next = 1'b1;
                end
                out_vld_next = st8_reg.last;
            end
        end
        out_hit_next = found_next;
        out_idx_next = found_next ? bidx_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            best_reg    <= '0;
            bidx_reg    <= '0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[6:0], !empty};
            best_reg    <= best_next;
            bidx_reg    <= bidx_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
            if (!empty && (pop_item.kind == KIND_SETUP))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    org_reg[i] <= pos[i];
                    dir_reg[i] <= pdir[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg     <= st1_next;
            st2_reg     <= st2_next;
            st3_reg     <= st3_next;
            st4_reg     <= st4_next;
            st5_reg     <= st5_next;
            st6_reg     <= st6_next;
            st7_reg     <= st7_next;
            st8_reg     <= st8_next;
            out_hit_reg <= out_hit_next;
            out_idx_reg <= out_idx_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_idx_reg);

`ifndef ASSERT_OFF
    a_setup_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[7] && (st8_reg.kind == KIND_SETUP)) |=> !found_reg)
        else $error("setup did not clear found");
    a_idx_cap: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (bidx_reg <= IDX_CAP))
        else $error("best index past cap");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_hit_reg) |-> (out_idx_reg == '0))
        else $error("miss result with nonzero index");
`endif

endmodule

### design/ray_pick_nearest_sphere.sv
// Nearest-sphere ray pick. A setup transaction (tuser 0) loads the ray origin, unit direction
// and largest distance and clears the running best; each node transaction (tuser 1) tests one
// sphere, and the node transaction with tlast set returns one result: tuser = hit, tdata =
// index of the nearest hit node in arrival order (0 on a miss). Nodes are indexed from 0 after
// each setup and the index saturates at 1023. The block sustains one transaction per cycle while
// the result side does not stall. A front stage numbers nodes and writes them into a 4-entry
// queue; an 8-stage back pipeline (offset, dot products, dot sum, projection, perpendicular
// error, magnitude, squares, compare) then updates the running best and registers the result.
// A stall on the result side freezes the back pipeline; the front keeps accepting until the
// queue is full.
module ray_pick_nearest_sphere
    import rpns_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // px, py, pz, dir_x, dir_y, dir_z, max_dist, node_size
    input  logic                 s_axis_tuser,  // kind
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // node_index
    output logic                 m_axis_tuser   // hit
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    item_t push_item;
    item_t pop_item;

    rpns_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_item     (push_item),
        .full          (full)
    );

    rpns_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    rpns_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .pop_item      (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### verif/tb_ray_pick_nearest_sphere.sv
module tb_ray_pick_nearest_sphere
    import rpns_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS = 24;
    localparam int SAT_NODES = 1032;

    typedef struct packed {
        kind_t                     kind;
        logic                      last;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic [DIST_W-1:0]         max_dist;
        logic [DIST_W-1:0]         size;
    } ray_item_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } pick_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // px, py, pz, dir_x, dir_y, dir_z, max_dist, node_size
    logic                 s_axis_tuser = 1'b0;  // kind
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;  // node_index
    logic                 m_axis_tuser;  // hit

    ray_pick_nearest_sphere dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ray_item_t ray_items[$];
    ray_item_t cur_item;
    pick_t     expected_picks[$];
    pick_t     want;

    logic signed [COORD_W-1:0] ray_org[3];
    logic signed [DIR_W-1:0]   ray_dir[3];
    logic [31:0]               best_t;
    logic [IDX_W-1:0]          best_idx;
    logic [IDX_W-1:0]          node_cnt;
    logic                      have_hit;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_cycles = 0;
    int items_sent = 0;
    int scans_made = 0;
    int picks_seen = 0;
    int hits_seen = 0;
    int sat_seen = 0;
    int mismatches = 0;

    function automatic void pick_update(input ray_item_t it);
        longint d[3];
        longint dot;
        longint tt;
        longint e;
        longint p;
        logic [65:0] sum;
        logic [65:0] sz;
        logic [IDX_W-1:0] idx;
        bit ok;
        pick_t pk;
        if (it.kind == KIND_SETUP)
        begin
            ray_org[0] = it.px;
            ray_org[1] = it.py;
            ray_org[2] = it.pz;
            ray_dir[0] = it.dir_x;
            ray_dir[1] = it.dir_y;
            ray_dir[2] = it.dir_z;
            best_t = {1'b0, it.max_dist};
            best_idx = '0;
            have_hit = 1'b0;
            node_cnt = '0;
            return;
        end
        idx = node_cnt;
        if (node_cnt < IDX_CAP)
            node_cnt = node_cnt + 1'b1;
        d[0] = longint'(it.px) - longint'(ray_org[0]);
        d[1] = longint'(it.py) - longint'(ray_org[1]);
        d[2] = longint'(it.pz) - longint'(ray_org[2]);
        dot = 0;
        for (int k = 0; k < 3; k++)
            dot += d[k] * longint'(ray_dir[k]);
        ok = (dot >= 0);
        tt = dot >>> DIR_FRAC;
        if (ok && tt >= longint'(best_t))
            ok = 1'b0;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (ok)
            begin
                e = d[k] * (longint'(1) << DIR_FRAC) - longint'(ray_dir[k]) * tt;
                p = ((e < 0) ? -e : e) >>> DIR_FRAC;
                if (p >= (longint'(1) << 30))
                    ok = 1'b0;
                else
                    sum += 66'(p) * 66'(p);
            end
        end
        sz = 66'(it.size);
        if (ok && (sum << 2) >= sz * sz)
            ok = 1'b0;
        if (ok)
        begin
            best_t = 32'(tt);
            best_idx = idx;
            have_hit = 1'b1;
        end
        if (it.last)
        begin
            pk.hit = have_hit;
            pk.idx = have_hit ? best_idx : '0;
            expected_picks = {expected_picks, pk};
        end
    endfunction

    function automatic void add_setup(input logic signed [COORD_W-1:0] ox, oy, oz,
                                      input logic signed [DIR_W-1:0] dx, dy, dz,
                                      input logic [DIST_W-1:0] md, input logic lst);
        ray_item_t it;
        it.kind = KIND_SETUP;
        it.last = lst;
        it.px = ox;
        it.py = oy;
        it.pz = oz;
        it.dir_x = dx;
        it.dir_y = dy;
        it.dir_z = dz;
        it.max_dist = md;
        it.size = DIST_W'($urandom);
        ray_items = {ray_items, it};
        scans_made++;
    endfunction

    function automatic void add_node(input logic signed [COORD_W-1:0] cx, cy, cz,
                                     input logic [DIST_W-1:0] sz, input logic lst);
        ray_item_t it;
        it.kind = KIND_NODE;
        it.last = lst;
        it.px = cx;
        it.py = cy;
        it.pz = cz;
        it.dir_x = DIR_W'($urandom);
        it.dir_y = DIR_W'($urandom);
        it.dir_z = DIR_W'($urandom);
        it.max_dist = DIST_W'($urandom);
        it.size = sz;
        ray_items = {ray_items, it};
    endfunction

    function automatic void add_scan(input int n_nodes);
        logic signed [COORD_W-1:0] o[3];
        logic signed [COORD_W-1:0] c[3];
        logic signed [DIR_W-1:0]   dv[3];
        logic [DIST_W-1:0]         md;
        logic [DIST_W-1:0]         sz;
        longint tt;
        longint jit;
        int mode;
        int ax;
        int r;
        bit lst;
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(9) == 0)
                o[k] = COORD_W'($urandom);
            else
                o[k] = COORD_W'($urandom_range(1 << 25)) - COORD_W'(1 << 24);
            dv[k] = '0;
        end
        mode = $urandom_range(3);
        ax = $urandom_range(2);
        case (mode)
            0: dv[ax] = $urandom_range(1) ? DIR_W'(16384) : -DIR_W'(16384);
            1:
            begin
                dv[ax] = $urandom_range(1) ? DIR_W'(11585) : -DIR_W'(11585);
                dv[(ax + 1) % 3] = $urandom_range(1) ? DIR_W'(11585) : -DIR_W'(11585);
            end
            2:
            begin
                for (int k = 0; k < 3; k++)
                    dv[k] = DIR_W'($urandom_range(32768)) - DIR_W'(16384);
            end
            default:
            begin
                for (int k = 0; k < 3; k++)
                    dv[k] = $urandom_range(1) ? DIR_W'(9459) : -DIR_W'(9459);
            end
        endcase
        r = $urandom_range(19);
        if (r == 0)
            md = '0;
        else if (r < 3)
            md = DIST_W'($urandom);
        else
            md = DIST_W'($urandom_range(1 << 26, 1 << 12));
        add_setup(o[0], o[1], o[2], dv[0], dv[1], dv[2], md, $urandom_range(15) == 0);
        sz = '0;
        c[0] = '0;
        c[1] = '0;
        c[2] = '0;
        for (int i = 0; i < n_nodes; i++)
        begin
            lst = (i == n_nodes - 1) || ($urandom_range(19) == 0);
            r = $urandom_range(11);
            if (r == 0 && i != 0)
                add_node(c[0], c[1], c[2], sz, lst);
            else if (r < 4)
                add_node(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                         DIST_W'($urandom), lst);
            else
            begin
                tt = longint'($urandom_range(32'(md) + 32'(md >> 2)));
                sz = ($urandom_range(9) == 0) ? DIST_W'($urandom)
                                              : DIST_W'($urandom_range(1 << 22));
                for (int k = 0; k < 3; k++)
                begin
                    jit = longint'($urandom_range(32'(sz))) - longint'(sz >> 1);
                    c[k] = COORD_W'(longint'(o[k]) + ((longint'(dv[k]) * tt) >>> DIR_FRAC)
                                    + jit);
                end
                add_node(c[0], c[1], c[2], sz, lst);
            end
        end
    endfunction

    function automatic void report_pick(input string what, input bit have_want);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (have_want)
                $display("%s at %0t: expected hit=%0b index=%0d, got hit=%0b tdata=%0d",
                         what, $time, want.hit, want.idx, m_axis_tuser, m_axis_tdata);
            else
                $display("%s at %0t: got hit=%0b tdata=%0d",
                         what, $time, m_axis_tuser, m_axis_tdata);
        end
    endfunction

    // driver: predict on acceptance, then load the next transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pick_update(cur_item);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (ray_items.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    cur_item = ray_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cur_item.kind;
                    s_axis_tlast <= cur_item.last;
                    s_axis_tdata <= {2'b00, cur_item.size, cur_item.max_dist,
                                     cur_item.dir_z, cur_item.dir_y, cur_item.dir_x,
                                     cur_item.pz, cur_item.py, cur_item.px};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && picks_seen >= 12)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            picks_seen <= picks_seen + 1;
            if (expected_picks.size() == 0)
            begin
                report_pick("unexpected result", 1'b0);
            end
            else
            begin
                want = expected_picks.pop_front();
                if (want.hit)
                    hits_seen <= hits_seen + 1;
                if (want.hit && want.idx == IDX_CAP)
                    sat_seen <= sat_seen + 1;
                if (m_axis_tuser !== want.hit || m_axis_tdata !== M_TDATA_W'(want.idx))
                    report_pick("result mismatch", 1'b1);
            end
        end
    end

    // watchdog: count cycles without progress while work is outstanding
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (ray_items.size() == 0 && !s_axis_tvalid && expected_picks.size() == 0))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", stall_cycles);
            $display("ray_pick_nearest_sphere verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int made;
        int n;
        int snd_plan[4];
        int rcv_plan[4];
        snd_plan = '{0, 73, 0, 25};
        rcv_plan = '{0, 0, 73, 25};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // node before any setup, then a setup whose last mark is ignored
        add_node(32'sd0, 32'sd0, 32'sd0, 31'h7FFFFFFF, 1'b1);
        add_setup(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 31'h7FFFFFFF, 1'b1);
        // hit, tie with the same node, zero size, behind the origin, far off the ray
        add_node(32'sd10 <<< 16, 32'sd0, 32'sd0, 31'd2 << 16, 1'b0);
        add_node(32'sd10 <<< 16, 32'sd0, 32'sd0, 31'd2 << 16, 1'b0);
        add_node(32'sd5 <<< 16, 32'sd0, 32'sd0, 31'd0, 1'b0);
        add_node(-(32'sd3 <<< 16), 32'sd0, 32'sd0, 31'h7FFFFFFF, 1'b0);
        add_node(32'sd1 <<< 16, 32'sh7FFFFFFF, 32'sd0, 31'h7FFFFFFF, 1'b1);
        // scan keeps going past the last mark
        add_node(32'sd2 <<< 16, 32'sd0, 32'sd0, 31'd1 << 16, 1'b1);
        // extreme origin, unnormalized direction, zero distance
        add_setup(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                  -16'sd16384, 16'sd16384, -16'sd16384, 31'd0, 1'b0);
        add_node(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 1'b1);
        // large projections rejected against the best distance
        add_setup(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                  16'sd0, 16'sd0, -16'sd16384, 31'h7FFFFFFF, 1'b0);
        add_node(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 1'b0);
        add_node(32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 31'h7FFFFFFF, 1'b0);
        add_node(32'sh7FFFFFFF, 32'sh80000000 + 32'sd100, 32'sh7FFFFFFF - (32'sd50 <<< 16),
                 31'd1 << 16, 1'b1);
        // zero direction: every node projects to t = 0
        add_setup(32'sd12345, -32'sd999, 32'sd7, 16'sd0, 16'sd0, 16'sd0, 31'd1000, 1'b0);
        add_node(32'sd12345, -32'sd999, 32'sd7, 31'd1, 1'b0);
        add_node(32'sd12345, -32'sd999, 32'sd7, 31'd1, 1'b1);
        // diagonal, oversize direction
        add_setup(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd16384, 16'sd16384, 31'd1 << 30,
                  1'b0);
        add_node(32'sd3 <<< 16, 32'sd3 <<< 16, 32'sd3 <<< 16, 31'd4 << 16, 1'b0);
        add_node(32'sd1 <<< 16, 32'sd1 <<< 16, 32'sd1 <<< 16, 31'd1 << 16, 1'b1);

        // random rays
        made = 0;
        while (made < RAND_ITEMS)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            add_scan(n);
            made += n + 1;
        end

        // long scan across the four handshake mixes: each node nearer than the last,
        // so the index saturates
        add_setup(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 31'd1 << 30, 1'b0);
        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            snd_idle_pct = snd_plan[ph];
            rcv_stall_pct = rcv_plan[ph];
            for (int i = ph * (SAT_NODES / 4); i < (ph + 1) * (SAT_NODES / 4); i++)
                add_node(COORD_W'((SAT_NODES - i) << 10),
                         COORD_W'($urandom_range(128)) - 32'sd64,
                         COORD_W'($urandom_range(128)) - 32'sd64,
                         31'd1 << 8, (i % 50 == 49) || (i == SAT_NODES - 1));
            while (ray_items.size() != 0 || s_axis_tvalid)
                @(negedge clk);
        end

        while (expected_picks.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        mismatches += expected_picks.size();

        $display("sent %0d transactions over %0d ray setups under four handshake mixes",
                 items_sent, scans_made);
        $display("checked %0d picks: %0d hits, %0d at the saturated index",
                 picks_seen, hits_seen, sat_seen);
        if (mismatches == 0)
            $display("ray_pick_nearest_sphere verification clean");
        else
            $display("ray_pick_nearest_sphere verification failed");
        $finish;
    end

endmodule

### ray_pick_nearest_sphere.f
design/rpns_pkg.sv
design/rpns_queue.sv
design/rpns_front.sv
design/rpns_back.sv
design/ray_pick_nearest_sphere.sv
verif/tb_ray_pick_nearest_sphere.sv
